// File: rtl/hrv_pkg.sv
// Shared types and constants for the HRV time-domain metrics block.
// No dependencies; imported by every module of the block.
package hrv_pkg;

    localparam int ARITH_W    = 64;
    localparam int ITER_W     = 7;
    localparam logic [ITER_W-1:0] MUL_ITERS  = 7'd64;
    localparam logic [ITER_W-1:0] DIV_ITERS  = 7'd64;
    localparam logic [ITER_W-1:0] SQRT_ITERS = 7'd32;
    localparam logic [ARITH_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic [ARITH_W-1:0] PNN_SCALE = 64'd1600;
    localparam int Q_SHIFT = 8;
    localparam logic [19:0] MET_SAT = 20'hFFFFF;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FEW_RAW   = 2'd1;
    localparam logic [1:0] STAT_FEW_CLEAN = 2'd2;

    localparam logic [2:0] CFG_RANGE_MIN  = 3'd0;
    localparam logic [2:0] CFG_RANGE_MAX  = 3'd1;
    localparam logic [2:0] CFG_TOL_PCT    = 3'd2;
    localparam logic [2:0] CFG_TOL_FLOOR  = 3'd3;
    localparam logic [2:0] CFG_DIFF_LIMIT = 3'd4;
    localparam logic [2:0] CFG_MIN_CLEAN  = 3'd5;

    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_WIN_INIT, S_WIN_RD, S_WIN_CAP, S_MED, S_GATE, S_ACC,
        S_FIN, S_OP_ISSUE, S_OP_WAIT, S_RES_RAW, S_RES_CLEAN, S_RES_OK
    } t_state;

    typedef enum logic [3:0] {
        ST_MUL_CQ, ST_MUL_SS, ST_MUL_DEN, ST_DIV_SD, ST_SQRT_SD,
        ST_DIV_RM, ST_SQRT_RM, ST_MUL_PNN, ST_DIV_PNN
    } t_step;

    typedef enum logic [1:0] {AOP_MUL, AOP_DIV, AOP_SQRT} t_aop;

    typedef struct packed {
        logic [15:0] range_min;
        logic [15:0] range_max;
        logic [6:0]  tol_pct;
        logic [15:0] tol_floor;
        logic [15:0] diff_limit;
        logic [8:0]  min_clean;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic proc_init;
        logic win_init;
        logic win_cap;
        logic med_scan;
        logic gate;
        logic acc;
        logic op_issue;
        logic op_wait;
        logic res_raw;
        logic res_clean;
        logic res_ok;
    } t_cmd;

    typedef struct packed {
        logic last_acc;
        logic raw_lt3;
        logic n_zero;
        logic j_at_b;
        logic med_found;
        logic i_last;
        logic clean_short;
        logic step_last;
        logic arith_done;
        logic out_busy;
    } t_stat;

endpackage

// File: rtl/hrv_time_domain_metrics.sv
// Top level of the HRV time-domain metrics block: configuration registers and wiring.
// Depends on hrv_pkg, hrv_ctrl, hrv_dp (which holds hrv_arith).
//
// Intervals (ms) are taken one per cycle while loading; the ones inside the
// range gate are written to an on-chip store of MAX_INTERVALS entries, extras
// are counted but not stored. The request flagged last_interval closes the run
// and the input stalls while the run is processed: for every stored interval
// the window of up to 2*HALF_WINDOW+1 neighbours is read from the store, each
// entry in a read state and then a capture state (single read port, registered
// data), the median is found by testing one candidate per cycle, then the gate
// and accumulate states follow. The closing math runs on one shared bit-serial
// unit: four multiplies, three divides and two square roots. One result
// request follows per run; it sits in an output register, and the next run
// loads while it waits, processing holding at the end until it is taken.
// Configuration writes are always accepted; change registers only while idle.
module hrv_time_domain_metrics #(
    parameter int MAX_INTERVALS = 256,
    parameter int HALF_WINDOW   = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_interval_ms,
    input  logic        i_last_interval,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [19:0] o_sdnn_q4,
    output logic [19:0] o_rmssd_q4,
    output logic [10:0] o_pnn50_q4,
    output logic [8:0]  o_clean_count,
    output logic [15:0] o_removed_count
);
    import hrv_pkg::*;

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_min  <= 16'd400;
            r_cfg.range_max  <= 16'd1200;
            r_cfg.tol_pct    <= 7'd20;
            r_cfg.tol_floor  <= 16'd120;
            r_cfg.diff_limit <= 16'd50;
            r_cfg.min_clean  <= 9'd5;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RANGE_MIN:  r_cfg.range_min  <= i_cfg_data;
                CFG_RANGE_MAX:  r_cfg.range_max  <= i_cfg_data;
                CFG_TOL_PCT:    r_cfg.tol_pct    <= i_cfg_data[6:0];
                CFG_TOL_FLOOR:  r_cfg.tol_floor  <= i_cfg_data;
                CFG_DIFF_LIMIT: r_cfg.diff_limit <= i_cfg_data;
                CFG_MIN_CLEAN:  r_cfg.min_clean  <= i_cfg_data[8:0];
                default:        ;
            endcase
        end
    end

    hrv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    hrv_dp #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .HALF_WINDOW   (HALF_WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_in_valid      (i_in_valid),
        .i_interval_ms   (i_interval_ms),
        .i_last_interval (i_last_interval),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_sdnn_q4       (o_sdnn_q4),
        .o_rmssd_q4      (o_rmssd_q4),
        .o_pnn50_q4      (o_pnn50_q4),
        .o_clean_count   (o_clean_count),
        .o_removed_count (o_removed_count)
    );

    // input stalls only outside the load phase
    assign o_in_stall = !w_cmd.load;

    // closing request always ends the load phase
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_interval) |=> o_in_stall)
        else $error("load phase continued after last interval");

    // a new result only appears while processing holds the input
    a_result_from_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised outside processing");

    // under-three-raw results carry no metrics
    a_few_raw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_FEW_RAW) |->
        (o_sdnn_q4 == '0 && o_clean_count == '0 && o_removed_count < 16'd3))
        else $error("under-three-raw result not cleared");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3 && o_pnn50_q4 <= 11'd1600))
        else $error("result fields out of range");

endmodule

// File: rtl/hrv_arith.sv
// Shared multi-cycle 64-bit unit: shift-add multiply, restoring divide, bitwise square root.
// Depends on hrv_pkg.
module hrv_arith (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  hrv_pkg::t_aop         i_op,
    input  logic [63:0]           i_a,
    input  logic [63:0]           i_b,
    output logic                  o_done,
    output logic [63:0]           o_res
);
    import hrv_pkg::*;

    logic              r_busy, r_done;
    t_aop              r_op;
    logic [ITER_W-1:0] r_cnt;
    logic [63:0]       r_x, r_y;
    logic [64:0]       r_acc;
    logic [64:0]       w_rem_sh;
    logic [63:0]       w_t;

    assign w_rem_sh = {r_acc[63:0], r_x[63]};
    assign w_t      = r_acc[63:0] + r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_x   <= i_a;
            r_acc <= '0;
            case (i_op)
                AOP_MUL: begin
                    r_y   <= i_b;
                    r_cnt <= MUL_ITERS - 7'd1;
                end
                AOP_DIV: begin
                    r_y   <= i_b;
                    r_cnt <= DIV_ITERS - 7'd1;
                end
                default: begin
                    r_y   <= SQRT_BIT0;
                    r_cnt <= SQRT_ITERS - 7'd1;
                end
            endcase
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            case (r_op)
                AOP_MUL: begin
                    if (r_y[0]) r_acc <= {1'b0, r_acc[63:0] + r_x};
                    r_x <= {r_x[62:0], 1'b0};
                    r_y <= {1'b0, r_y[63:1]};
                end
                AOP_DIV: begin
                    if (w_rem_sh >= {1'b0, r_y}) begin
                        r_acc <= w_rem_sh - {1'b0, r_y};
                        r_x   <= {r_x[62:0], 1'b1};
                    end else begin
                        r_acc <= w_rem_sh;
                        r_x   <= {r_x[62:0], 1'b0};
                    end
                end
                default: begin
                    if (r_x >= w_t) begin
                        r_x   <= r_x - w_t;
                        r_acc <= {1'b0, {1'b0, r_acc[63:1]} + r_y};
                    end else begin
                        r_acc <= {1'b0, 1'b0, r_acc[63:1]};
                    end
                    r_y <= {2'b00, r_y[63:2]};
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == AOP_DIV) ? r_x : r_acc[63:0];

endmodule

// File: rtl/hrv_dp.sv
// Datapath: interval store, median window, gating, accumulators, final math, result register.
// Depends on hrv_pkg and hrv_arith.
module hrv_dp #(
    parameter int MAX_INTERVALS = 256,
    parameter int HALF_WINDOW   = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrv_pkg::t_cfg   i_cfg,
    input  hrv_pkg::t_cmd   i_cmd,
    output hrv_pkg::t_stat  o_stat,
    input  logic            i_in_valid,
    input  logic [15:0]     i_interval_ms,
    input  logic            i_last_interval,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [1:0]      o_status,
    output logic [19:0]     o_sdnn_q4,
    output logic [19:0]     o_rmssd_q4,
    output logic [10:0]     o_pnn50_q4,
    output logic [8:0]      o_clean_count,
    output logic [15:0]     o_removed_count
);
    import hrv_pkg::*;

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int EW = CW + 6;
    localparam int W  = 2 * HALF_WINDOW + 1;
    localparam int LW = $clog2(W + 1);
    localparam int KW = $clog2(W);
    localparam int SW = CW + 16;
    localparam int QW = CW + 32;
    localparam int NW = (CW > 9) ? CW : 9;

    logic [15:0]   r_mem [MAX_INTERVALS];
    logic [15:0]   r_rd;
    logic [15:0]   r_raw;
    logic [CW-1:0] r_n;
    logic [AW-1:0] r_i, r_j, r_b;
    logic [15:0]   r_win [W];
    logic [LW-1:0] r_len;
    logic [KW-1:0] r_k;
    logic [15:0]   r_cur, r_med, r_prev, r_dd;
    logic          r_keep;
    logic [CW-1:0] r_clean;
    logic [SW-1:0] r_s;
    logic [QW-1:0] r_q, r_dsq;
    logic [CW-1:0] r_nn;
    t_step         r_step;
    logic [63:0]   r_num, r_den, r_t;
    logic [19:0]   r_sdnn, r_rmssd;
    logic [10:0]   r_pnn;
    logic          r_out_valid;

    logic          w_in_acc, w_in_range, w_store;
    logic [EW-1:0] w_hi;
    logic [AW-1:0] w_a, w_b;
    logic [LW-1:0] w_less, w_le, w_half;
    logic          w_found;
    logic [15:0]   w_d, w_dp;
    logic [22:0]   w_lhs, w_rhs;
    logic [31:0]   w_vsq, w_dsq;
    logic [8:0]    w_need;
    logic [63:0]   w_cm1, w_opa, w_opb, w_res, w_sat_src;
    t_aop          w_op;
    logic          w_done;
    logic [19:0]   w_sat;

    // load path
    assign w_in_acc   = i_in_valid && i_cmd.load;
    assign w_in_range = (i_interval_ms >= i_cfg.range_min) && (i_interval_ms <= i_cfg.range_max);
    assign w_store    = w_in_acc && w_in_range && (r_n < CW'(MAX_INTERVALS));

    always_ff @(posedge i_clk) begin
        if (w_store) r_mem[r_n[AW-1:0]] <= i_interval_ms;
        r_rd <= r_mem[r_j];
    end

    // window bounds, clipped at the run ends
    assign w_hi = EW'(r_i) + EW'(HALF_WINDOW);
    assign w_a  = (EW'(r_i) >= EW'(HALF_WINDOW)) ? AW'(EW'(r_i) - EW'(HALF_WINDOW)) : '0;
    assign w_b  = (w_hi < EW'(r_n)) ? AW'(w_hi) : AW'(r_n - CW'(1));

    // rank test of candidate r_k against the window
    always_comb begin
        w_less = '0;
        w_le   = '0;
        for (int e = 0; e < W; e++) begin
            if (LW'(e) < r_len) begin
                if (r_win[e] < r_win[r_k]) w_less = w_less + LW'(1);
                if (r_win[e] <= r_win[r_k]) w_le = w_le + LW'(1);
            end
        end
    end
    assign w_half  = r_len >> 1;
    assign w_found = (w_less <= w_half) && (w_half < w_le);

    // tolerance gate
    assign w_d   = (r_cur >= r_med) ? r_cur - r_med : r_med - r_cur;
    assign w_lhs = 23'(w_d) * 23'd100;
    assign w_rhs = 23'(i_cfg.tol_pct) * 23'(r_med);
    assign w_dp  = (r_cur >= r_prev) ? r_cur - r_prev : r_prev - r_cur;
    assign w_vsq = 32'(r_cur) * 32'(r_cur);
    assign w_dsq = 32'(r_dd) * 32'(r_dd);

    assign w_need = (i_cfg.min_clean < 9'd2) ? 9'd2 : i_cfg.min_clean;
    assign w_cm1  = 64'(r_clean) - 64'd1;

    always_comb begin
        w_op  = AOP_MUL;
        w_opa = 64'(r_clean);
        w_opb = 64'(r_q);
        case (r_step)
            ST_MUL_CQ:  ;
            ST_MUL_SS: begin
                w_opa = 64'(r_s);
                w_opb = 64'(r_s);
            end
            ST_MUL_DEN: w_opb = w_cm1;
            ST_DIV_SD: begin
                w_op  = AOP_DIV;
                w_opa = r_num << Q_SHIFT;
                w_opb = r_den;
            end
            ST_SQRT_SD, ST_SQRT_RM: begin
                w_op  = AOP_SQRT;
                w_opa = r_t;
            end
            ST_DIV_RM: begin
                w_op  = AOP_DIV;
                w_opa = 64'(r_dsq) << Q_SHIFT;
                w_opb = w_cm1;
            end
            ST_MUL_PNN: begin
                w_opa = 64'(r_nn);
                w_opb = PNN_SCALE;
            end
            ST_DIV_PNN: begin
                w_op  = AOP_DIV;
                w_opa = r_t;
                w_opb = w_cm1;
            end
            default: ;
        endcase
    end

    hrv_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op_issue),
        .i_op    (w_op),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    assign w_sat_src = w_res;
    assign w_sat     = (w_sat_src > 64'(MET_SAT)) ? MET_SAT : w_sat_src[19:0];

    // run counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= '0;
            r_n   <= '0;
        end else if (i_cmd.res_raw || i_cmd.res_clean || i_cmd.res_ok) begin
            r_raw <= '0;
            r_n   <= '0;
        end else if (w_in_acc) begin
            if (r_raw != 16'hFFFF) r_raw <= r_raw + 16'd1;
            if (w_store) r_n <= r_n + CW'(1);
        end
    end

    // walk over the stored run
    always_ff @(posedge i_clk) begin
        if (i_cmd.proc_init) begin
            r_i     <= '0;
            r_clean <= '0;
            r_s     <= '0;
            r_q     <= '0;
            r_dsq   <= '0;
            r_nn    <= '0;
            r_prev  <= '0;
            r_step  <= ST_MUL_CQ;
        end
        if (i_cmd.win_init) begin
            r_j   <= w_a;
            r_b   <= w_b;
            r_len <= '0;
        end
        if (i_cmd.win_cap) begin
            r_win[r_len[KW-1:0]] <= r_rd;
            r_len <= r_len + LW'(1);
            r_k   <= '0;
            if (r_j == r_i) r_cur <= r_rd;
            if (r_j != r_b) r_j <= r_j + AW'(1);
        end
        if (i_cmd.med_scan) begin
            if (w_found) r_med <= r_win[r_k];
            else r_k <= r_k + KW'(1);
        end
        if (i_cmd.gate) begin
            r_keep <= (w_lhs <= w_rhs) || (w_d <= i_cfg.tol_floor);
            r_dd   <= w_dp;
        end
        if (i_cmd.acc) begin
            r_i <= r_i + AW'(1);
            if (r_keep) begin
                r_s     <= r_s + SW'(r_cur);
                r_q     <= r_q + QW'(w_vsq);
                r_prev  <= r_cur;
                r_clean <= r_clean + CW'(1);
                if (r_clean != '0) begin
                    r_dsq <= r_dsq + QW'(w_dsq);
                    if (r_dd > i_cfg.diff_limit) r_nn <= r_nn + CW'(1);
                end
            end
        end
        if (i_cmd.op_wait && w_done) begin
            r_step <= t_step'(4'(r_step) + 4'd1);
            case (r_step)
                ST_MUL_CQ:  r_num   <= w_res;
                ST_MUL_SS:  r_num   <= r_num - w_res;
                ST_MUL_DEN: r_den   <= w_res;
                ST_SQRT_SD: r_sdnn  <= w_sat;
                ST_SQRT_RM: r_rmssd <= w_sat;
                ST_DIV_PNN: r_pnn   <= w_res[10:0];
                default:    r_t     <= w_res;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cmd.res_raw || i_cmd.res_clean || i_cmd.res_ok) r_out_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_raw) begin
            o_status        <= STAT_FEW_RAW;
            o_sdnn_q4       <= '0;
            o_rmssd_q4      <= '0;
            o_pnn50_q4      <= '0;
            o_clean_count   <= '0;
            o_removed_count <= r_raw;
        end else if (i_cmd.res_clean || i_cmd.res_ok) begin
            o_status        <= i_cmd.res_ok ? STAT_OK : STAT_FEW_CLEAN;
            o_sdnn_q4       <= i_cmd.res_ok ? r_sdnn : '0;
            o_rmssd_q4      <= i_cmd.res_ok ? r_rmssd : '0;
            o_pnn50_q4      <= i_cmd.res_ok ? r_pnn : '0;
            o_clean_count   <= 9'(r_clean);
            o_removed_count <= r_raw - 16'(r_clean);
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_stat.last_acc    = w_in_acc && i_last_interval;
    assign o_stat.raw_lt3     = r_raw < 16'd3;
    assign o_stat.n_zero      = r_n == '0;
    assign o_stat.j_at_b      = r_j == r_b;
    assign o_stat.med_found   = w_found;
    assign o_stat.i_last      = CW'(r_i) == (r_n - CW'(1));
    assign o_stat.clean_short = NW'(r_clean) < NW'(w_need);
    assign o_stat.step_last   = r_step == ST_DIV_PNN;
    assign o_stat.arith_done  = w_done;
    assign o_stat.out_busy    = r_out_valid && i_out_stall;

endmodule

// File: rtl/hrv_ctrl.sv
// Controller state machine: load, per-interval median gating walk, final math sequence.
// Depends on hrv_pkg.
module hrv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hrv_pkg::t_stat i_stat,
    output hrv_pkg::t_cmd  o_cmd
);
    import hrv_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:     if (i_stat.last_acc) n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.raw_lt3) n_state = S_RES_RAW;
                else if (i_stat.n_zero) n_state = S_FIN;
                else n_state = S_WIN_INIT;
            end
            S_WIN_INIT: n_state = S_WIN_RD;
            S_WIN_RD:   n_state = S_WIN_CAP;
            S_WIN_CAP:  n_state = i_stat.j_at_b ? S_MED : S_WIN_RD;
            S_MED:      if (i_stat.med_found) n_state = S_GATE;
            S_GATE:     n_state = S_ACC;
            S_ACC:      n_state = i_stat.i_last ? S_FIN : S_WIN_INIT;
            S_FIN:      n_state = i_stat.clean_short ? S_RES_CLEAN : S_OP_ISSUE;
            S_OP_ISSUE: n_state = S_OP_WAIT;
            S_OP_WAIT: begin
                if (i_stat.arith_done) n_state = i_stat.step_last ? S_RES_OK : S_OP_ISSUE;
            end
            S_RES_RAW, S_RES_CLEAN, S_RES_OK: if (!i_stat.out_busy) n_state = S_LOAD;
            default:    n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_LOAD:      o_cmd.load      = 1'b1;
            S_CHECK:     o_cmd.proc_init = 1'b1;
            S_WIN_INIT:  o_cmd.win_init  = 1'b1;
            S_WIN_CAP:   o_cmd.win_cap   = 1'b1;
            S_MED:       o_cmd.med_scan  = 1'b1;
            S_GATE:      o_cmd.gate      = 1'b1;
            S_ACC:       o_cmd.acc       = 1'b1;
            S_OP_ISSUE:  o_cmd.op_issue  = 1'b1;
            S_OP_WAIT:   o_cmd.op_wait   = 1'b1;
            S_RES_RAW:   o_cmd.res_raw   = !i_stat.out_busy;
            S_RES_CLEAN: o_cmd.res_clean = !i_stat.out_busy;
            S_RES_OK:    o_cmd.res_ok    = !i_stat.out_busy;
            default:     ;
        endcase
    end

endmodule

// File: tb/hrv_time_domain_metrics_tb.sv
// Self-checking testbench for hrv_time_domain_metrics: directed and random runs of beat
// intervals are checked against an in-bench predictor of SDNN, RMSSD, pNN50, status and counts.
// Depends on hrv_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module hrv_time_domain_metrics_tb;
    import hrv_pkg::*;

    localparam int CAPACITY = 256;
    localparam int HALF_WIN = 5;

    typedef struct {
        logic [15:0] interval;
        logic        last;
    } t_beat;

    typedef struct {
        logic [1:0]  status;
        logic [19:0] sdnn;
        logic [19:0] rmssd;
        logic [10:0] pnn50;
        logic [8:0]  clean;
        logic [15:0] removed;
    } t_metrics;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_interval_ms = '0;
    logic        i_last_interval = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [19:0] o_sdnn_q4;
    logic [19:0] o_rmssd_q4;
    logic [10:0] o_pnn50_q4;
    logic [8:0]  o_clean_count;
    logic [15:0] o_removed_count;

    hrv_time_domain_metrics DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pending beats, expected metrics, bookkeeping
    t_beat    beat_q[$];
    t_metrics metrics_q[$];
    int       fail_cnt = 0;
    int       beats_sent = 0;
    int       runs_sent = 0;
    int       results_seen = 0;
    int       status_seen[3] = '{0, 0, 0};
    int       cap_runs = 0;

    // Predictor copy of the registers and run state
    logic [15:0] p_rmin = 16'd400, p_rmax = 16'd1200;
    logic [6:0]  p_tol = 7'd20;
    logic [15:0] p_floor = 16'd120, p_dlim = 16'd50;
    logic [8:0]  p_minc = 9'd5;
    logic [15:0] run_store[CAPACITY];
    int          stored_n = 0;
    int          raw_n = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Median of the clipped +-HALF_WIN window; upper middle for even counts
    function automatic int window_median(int idx, int n);
        int w[2*HALF_WIN+1];
        int lo, hi, len, k, v;
        lo  = (idx >= HALF_WIN) ? idx - HALF_WIN : 0;
        hi  = (idx + HALF_WIN < n) ? idx + HALF_WIN : n - 1;
        len = 0;
        for (int j = lo; j <= hi; j++) begin
            v = run_store[j];
            k = len;
            while (k > 0 && w[k-1] > v) begin
                w[k] = w[k-1];
                k--;
            end
            w[k] = v;
            len++;
        end
        return w[len/2];
    endfunction

    // Takes one accepted beat; on the closing beat queues the expected metrics
    task automatic take_beat(logic [15:0] x, logic last);
        t_metrics        r;
        int              clean, need, m, d;
        int              kept[CAPACITY];
        longint unsigned s, q, dsq, nn, num, den, sd, rm, dd;
        if (raw_n < 65535) raw_n++;
        if (x >= p_rmin && x <= p_rmax && stored_n < CAPACITY) begin
            run_store[stored_n] = x;
            stored_n++;
        end
        if (!last) return;
        r = '{STAT_OK, 0, 0, 0, 0, 0};
        clean = 0;
        if (raw_n < 3) begin
            r.status = STAT_FEW_RAW;
        end else begin
            for (int i = 0; i < stored_n; i++) begin
                m = window_median(i, stored_n);
                d = (run_store[i] >= m) ? run_store[i] - m : m - run_store[i];
                if (longint'(d) * 100 <= longint'(p_tol) * m || d <= p_floor) begin
                    kept[clean] = run_store[i];
                    clean++;
                end
            end
            need = (p_minc < 2) ? 2 : p_minc;
            if (clean < need) begin
                r.status = STAT_FEW_CLEAN;
            end else begin
                s = 0; q = 0; dsq = 0; nn = 0;
                for (int i = 0; i < clean; i++) begin
                    s += kept[i];
                    q += longint'(kept[i]) * kept[i];
                    if (i > 0) begin
                        dd = (kept[i] >= kept[i-1]) ? kept[i] - kept[i-1]
                                                    : kept[i-1] - kept[i];
                        dsq += dd * dd;
                        if (dd > p_dlim) nn++;
                    end
                end
                num = longint'(clean) * q - s * s;
                den = longint'(clean) * (clean - 1);
                sd  = int_sqrt((num * 256) / den);
                rm  = int_sqrt((dsq * 256) / (clean - 1));
                r.sdnn  = (sd > MET_SAT) ? MET_SAT : sd[19:0];
                r.rmssd = (rm > MET_SAT) ? MET_SAT : rm[19:0];
                r.pnn50 = 11'((nn * 1600) / (clean - 1));
            end
            r.clean = 9'(clean);
        end
        r.removed = 16'(raw_n - clean);
        metrics_q = {metrics_q, r};
        stored_n = 0;
        raw_n = 0;
    endtask

    // Sender: bursts and gaps; holds a stalled request unchanged
    logic in_taken = 1'b0;
    int   burst_left = 0, gap_left = 0;

    always @(negedge i_clk) begin
        logic  vld;
        t_beat b;
        vld = i_in_valid;
        if (!i_rst_n || !i_in_valid || in_taken) begin
            vld = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (beat_q.size() > 0) begin
                b = beat_q.pop_front();
                vld = 1'b1;
                i_interval_ms   <= b.interval;
                i_last_interval <= b.last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // about one burst in four runs without any gap after it
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_in_valid <= vld;
    end

    // Receiver stall pattern: four modes, picked at random
    int stall_mode = 0, stall_left = 0;

    always @(negedge i_clk) begin
        logic st;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        case (stall_mode)
            0: st = 1'b0;
            1: st = 1'($urandom_range(0, 1));
            2: st = ($urandom_range(0, 3) != 0);
            default: st = (stall_left > 5);
        endcase
        i_out_stall <= st;
    end

    // Monitor: predict on accepted beats, check accepted results
    always @(posedge i_clk) begin
        t_metrics e;
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            beats_sent++;
            take_beat(i_interval_ms, i_last_interval);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (metrics_q.size() == 0) begin
                $error("result with nothing expected");
                fail_cnt++;
            end else begin
                e = metrics_q.pop_front();
                if (o_status <= 2) status_seen[o_status]++;
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); fail_cnt++;
                end
                if (o_sdnn_q4 !== e.sdnn) begin
                    $error("sdnn_q4 exp %0d got %0d", e.sdnn, o_sdnn_q4); fail_cnt++;
                end
                if (o_rmssd_q4 !== e.rmssd) begin
                    $error("rmssd_q4 exp %0d got %0d", e.rmssd, o_rmssd_q4); fail_cnt++;
                end
                if (o_pnn50_q4 !== e.pnn50) begin
                    $error("pnn50_q4 exp %0d got %0d", e.pnn50, o_pnn50_q4); fail_cnt++;
                end
                if (o_clean_count !== e.clean) begin
                    $error("clean_count exp %0d got %0d", e.clean, o_clean_count);
                    fail_cnt++;
                end
                if (o_removed_count !== e.removed) begin
                    $error("removed_count exp %0d got %0d", e.removed, o_removed_count);
                    fail_cnt++;
                end
            end
        end
    end

    // Register write; the predictor copy follows the accepted write
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RANGE_MIN:  p_rmin  = val;
            CFG_RANGE_MAX:  p_rmax  = val;
            CFG_TOL_PCT:    p_tol   = val[6:0];
            CFG_TOL_FLOOR:  p_floor = val;
            CFG_DIFF_LIMIT: p_dlim  = val;
            CFG_MIN_CLEAN:  p_minc  = val[8:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int rmin, int rmax, int tol, int flr, int dl, int mc);
        write_reg(CFG_RANGE_MIN, 16'(rmin));
        write_reg(CFG_RANGE_MAX, 16'(rmax));
        write_reg(CFG_TOL_PCT, 16'(tol));
        write_reg(CFG_TOL_FLOOR, 16'(flr));
        write_reg(CFG_DIFF_LIMIT, 16'(dl));
        write_reg(CFG_MIN_CLEAN, 16'(mc));
    endtask

    // Waits until everything queued is out and every result is back
    task automatic drain();
        do @(posedge i_clk);
        while (beat_q.size() != 0 || i_in_valid || metrics_q.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_beat(int x, bit last);
        t_beat b;
        b.interval = 16'(x);
        b.last     = last;
        beat_q = {beat_q, b};
    endtask

    // One run: plausible rhythm with jitter, plus ectopic beats and junk
    task automatic add_run(int len);
        int base, x, kind;
        base = $urandom_range(450, 1150);
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 19);
            if (kind < 14)      x = base + $urandom_range(0, 160) - 80;
            else if (kind < 16) x = base / 2 + $urandom_range(0, 60);
            else if (kind < 18) x = base + base / 2 + $urandom_range(0, 200);
            else if (kind < 19) x = $urandom_range(0, 65535);
            else                x = ($urandom_range(0, 1)) ? 65535 : 0;
            add_beat(x, i == len - 1);
        end
        runs_sent++;
        if (len > CAPACITY) cap_runs++;
    endtask

    initial begin
        int len;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values: single beat, two beats, extremes, outlier
        add_beat(800, 1); runs_sent++;
        add_beat(800, 0); add_beat(820, 1); runs_sent++;
        add_beat(0, 0); add_beat(65535, 0); add_beat(700, 1); runs_sent++;
        add_beat(800, 0); add_beat(850, 0); add_beat(780, 0); add_beat(1190, 0);
        add_beat(810, 0); add_beat(400, 0); add_beat(1200, 0); add_beat(790, 1);
        runs_sent++;
        drain();

        // Wide-open gate, zero tolerances, smallest min_clean
        set_regs(0, 65535, 0, 0, 0, 2);
        add_beat(0, 0); add_beat(65535, 0); add_beat(0, 0); add_beat(65535, 1);
        runs_sent++;
        add_beat(600, 0); add_beat(600, 0); add_beat(600, 1); runs_sent++;
        drain();

        // Loosest tolerances, largest min_clean
        set_regs(0, 65535, 100, 65535, 65535, 256);
        add_run(10); add_run(CAPACITY + 20);
        drain();

        // Inverted range; min_clean below two
        set_regs(1000, 500, 50, 10, 20, 0);
        add_run(8);
        drain();
        set_regs(300, 1500, 10, 40, 30, 1);
        add_run(12);
        drain();

        // Random phases
        while (beats_sent + beat_q.size() < 2000) begin
            set_regs($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                               : $urandom_range(200, 500),
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                               : $urandom_range(1000, 2000),
                     $urandom_range(0, 100), $urandom_range(0, 3) == 0 ?
                     $urandom_range(0, 65535) : $urandom_range(0, 200),
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 120),
                     $urandom_range(0, 7) == 0 ? $urandom_range(0, 256)
                                               : $urandom_range(2, 8));
            for (int r = 0; r < 12; r++) begin
                len = ($urandom_range(0, 40) == 0) ? $urandom_range(CAPACITY, 300)
                                                   : $urandom_range(1, 30);
                add_run(len);
            end
            drain();
        end

        $display("Covered %0d runs (%0d past capacity), %0d beats, %0d results.",
                 runs_sent, cap_runs, beats_sent, results_seen);
        $display("Status mix: ok %0d, few raw %0d, few clean %0d.",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (fail_cnt == 0 && metrics_q.size() == 0) begin
            $display("hrv_time_domain_metrics test passed");
        end else begin
            $display("hrv_time_domain_metrics test failed");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("hrv_time_domain_metrics test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/hrv_pkg.sv
rtl/hrv_arith.sv
rtl/hrv_dp.sv
rtl/hrv_ctrl.sv
rtl/hrv_time_domain_metrics.sv
tb/hrv_time_domain_metrics_tb.sv
